// ===== src/stmrs_pkg.sv =====
// Package for the stepper ramp move sequencer.
// Holds the sequencer phase codes, the control register indexes and the register set type.
// No dependencies.
package stmrs_pkg;

   // Width used to compare counters against limits of different widths.
   localparam int CMP_BITS = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_HALF_PERIOD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_STEPS         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_START_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_DECREMENT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PAUSE_TICKS       = 3'd4;

   localparam logic [15:0] RUN_HALF_PERIOD_RST   = 16'd100;
   localparam logic [23:0] RUN_STEPS_RST         = 24'd320000;
   localparam logic [15:0] RAMP_START_PERIOD_RST = 16'd2000;
   localparam logic [7:0]  RAMP_DECREMENT_RST    = 8'd5;
   localparam logic [23:0] PAUSE_TICKS_RST       = 24'd500000;

   typedef enum logic [6:0] {
      PH_STARTUP   = 7'b0000001,
      PH_IDLE      = 7'b0000010,
      PH_RAMP_OUT  = 7'b0000100,
      PH_RUN_OUT   = 7'b0001000,
      PH_PAUSE     = 7'b0010000,
      PH_RAMP_BACK = 7'b0100000,
      PH_RUN_BACK  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [15:0] run_half_period;
      logic [23:0] run_steps;
      logic [15:0] ramp_start_half_period;
      logic [7:0]  ramp_decrement;
      logic [23:0] pause_ticks;
   } cfg_type;

endpackage

// ===== src/stmrs_csr.sv =====
// Control register set of the stepper ramp move sequencer.
// Decodes the plain write port into the five timing registers.
// Depends on stmrs_pkg.
module stmrs_csr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [stmrs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [stmrs_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output stmrs_pkg::cfg_type                       cfg
);

   stmrs_pkg::cfg_type cfg_ff;
   stmrs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            stmrs_pkg::REG_RUN_HALF_PERIOD:   cfg_in.run_half_period = csr_wdata[15:0];
            stmrs_pkg::REG_RUN_STEPS:         cfg_in.run_steps = csr_wdata[23:0];
            stmrs_pkg::REG_RAMP_START_PERIOD: cfg_in.ramp_start_half_period = csr_wdata[15:0];
            stmrs_pkg::REG_RAMP_DECREMENT:    cfg_in.ramp_decrement = csr_wdata[7:0];
            stmrs_pkg::REG_PAUSE_TICKS:       cfg_in.pause_ticks = csr_wdata[23:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_half_period        <= stmrs_pkg::RUN_HALF_PERIOD_RST;
         cfg_ff.run_steps              <= stmrs_pkg::RUN_STEPS_RST;
         cfg_ff.ramp_start_half_period <= stmrs_pkg::RAMP_START_PERIOD_RST;
         cfg_ff.ramp_decrement         <= stmrs_pkg::RAMP_DECREMENT_RST;
         cfg_ff.pause_ticks            <= stmrs_pkg::PAUSE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/stepper_ramp_move_sequencer_core.sv =====
// Stepper ramp move sequencer: one accepted tick in, one output-level result out.
// Latency: the result of a tick is shown the cycle after its transfer, from the output register.
// Throughput: one tick per cycle unless rsp_ready stalls, set by the single state-update stage.
// Reset (synchronous): start-up wait with default timing registers, levels low, output empty.
// Depends on stmrs_pkg and stmrs_csr.
module stepper_ramp_move_sequencer_core #(
   parameter int HALF_PERIOD_BITS = 16,
   parameter int COUNT_BITS       = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_trigger_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_step_clock,
   output logic                                   rsp_direction,
   output logic                                   rsp_driver_enable,
   input  logic                                   csr_write_enable,
   input  logic [stmrs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [stmrs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CW = stmrs_pkg::CMP_BITS;

   typedef struct packed {
      stmrs_pkg::phase_type        phase;
      logic [HALF_PERIOD_BITS-1:0] chp;
      logic [COUNT_BITS-1:0]       tc;
      logic [COUNT_BITS-1:0]       pc;
      logic                        clk;
      logic                        dir;
      logic                        en;
   } state_type;

   stmrs_pkg::cfg_type cfg;

   stmrs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   // Walk forward through phases that are skipped by their settings.
   function automatic state_type enter_phase(state_type s_in, stmrs_pkg::phase_type p_in,
                                             stmrs_pkg::cfg_type c);
      state_type            s;
      stmrs_pkg::phase_type p;
      logic                 done;
      s    = s_in;
      p    = p_in;
      done = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (!done) begin
            case (p)
               stmrs_pkg::PH_RAMP_OUT, stmrs_pkg::PH_RAMP_BACK: begin
                  s.chp = HALF_PERIOD_BITS'(c.ramp_start_half_period);
                  if (CW'(s.chp) > CW'(c.run_half_period)) begin
                     s.phase = p;
                     s.clk   = 1'b1;
                     s.tc    = '0;
                     done    = 1'b1;
                  end else if (p == stmrs_pkg::PH_RAMP_OUT) begin
                     p = stmrs_pkg::PH_RUN_OUT;
                  end else begin
                     p = stmrs_pkg::PH_RUN_BACK;
                  end
               end
               stmrs_pkg::PH_RUN_OUT, stmrs_pkg::PH_RUN_BACK: begin
                  if (c.run_steps != '0) begin
                     s.phase = p;
                     s.clk   = 1'b1;
                     s.tc    = '0;
                     s.pc    = '0;
                     done    = 1'b1;
                  end else if (p == stmrs_pkg::PH_RUN_OUT) begin
                     p = stmrs_pkg::PH_PAUSE;
                  end else begin
                     p = stmrs_pkg::PH_IDLE;
                  end
               end
               stmrs_pkg::PH_PAUSE: begin
                  s.dir = 1'b1;
                  s.clk = 1'b0;
                  if (c.pause_ticks != '0) begin
                     s.phase = p;
                     s.tc    = '0;
                     done    = 1'b1;
                  end else begin
                     p = stmrs_pkg::PH_RAMP_BACK;
                  end
               end
               default: begin
                  s.phase = stmrs_pkg::PH_IDLE;
                  s.en    = 1'b0;
                  s.clk   = 1'b0;
                  done    = 1'b1;
               end
            endcase
         end
      end
      return s;
   endfunction

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_step_clock_ff, rsp_direction_ff, rsp_driver_enable_ff;
   logic      out_clk, out_dir, out_en;
   logic      accept;
   logic [HALF_PERIOD_BITS-1:0] dec_ext;
   logic [CW-1:0]               run_dur;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign dec_ext   = HALF_PERIOD_BITS'(cfg.ramp_decrement);
   assign run_dur   = (cfg.run_half_period != '0) ? CW'(cfg.run_half_period) : CW'(1);

   always_comb begin
      state_type s;
      s = state_ff;

      if (s.phase == stmrs_pkg::PH_STARTUP && CW'(s.tc) >= CW'(cfg.pause_ticks)) begin
         s.phase = stmrs_pkg::PH_IDLE;
         s.tc    = '0;
         s.clk   = 1'b0;
         s.en    = 1'b0;
      end
      if (s.phase == stmrs_pkg::PH_IDLE && req_trigger_level) begin
         s.en  = 1'b1;
         s.dir = 1'b0;
         s     = enter_phase(s, stmrs_pkg::PH_RAMP_OUT, cfg);
      end

      out_clk = s.clk;
      out_dir = s.dir;
      out_en  = s.en;

      case (s.phase)
         stmrs_pkg::PH_STARTUP: begin
            s.tc = s.tc + COUNT_BITS'(1);
         end
         stmrs_pkg::PH_RAMP_OUT, stmrs_pkg::PH_RAMP_BACK: begin
            s.tc = s.tc + COUNT_BITS'(1);
            if (CW'(s.tc) >= CW'(s.chp)) begin
               s.tc = '0;
               if (s.clk) begin
                  s.clk = 1'b0;
               end else begin
                  s.chp = (s.chp > dec_ext) ? s.chp - dec_ext : '0;
                  if (CW'(s.chp) > CW'(cfg.run_half_period)) begin
                     s.clk = 1'b1;
                  end else if (s.phase == stmrs_pkg::PH_RAMP_OUT) begin
                     s = enter_phase(s, stmrs_pkg::PH_RUN_OUT, cfg);
                  end else begin
                     s = enter_phase(s, stmrs_pkg::PH_RUN_BACK, cfg);
                  end
               end
            end
         end
         stmrs_pkg::PH_RUN_OUT, stmrs_pkg::PH_RUN_BACK: begin
            s.tc = s.tc + COUNT_BITS'(1);
            if (CW'(s.tc) >= run_dur) begin
               s.tc = '0;
               if (s.clk) begin
                  s.clk = 1'b0;
               end else begin
                  s.pc = s.pc + COUNT_BITS'(1);
                  if (CW'(s.pc) < CW'(cfg.run_steps)) begin
                     s.clk = 1'b1;
                  end else if (s.phase == stmrs_pkg::PH_RUN_OUT) begin
                     s = enter_phase(s, stmrs_pkg::PH_PAUSE, cfg);
                  end else begin
                     s = enter_phase(s, stmrs_pkg::PH_IDLE, cfg);
                  end
               end
            end
         end
         stmrs_pkg::PH_PAUSE: begin
            s.tc = s.tc + COUNT_BITS'(1);
            if (CW'(s.tc) >= CW'(cfg.pause_ticks)) begin
               s = enter_phase(s, stmrs_pkg::PH_RAMP_BACK, cfg);
            end
         end
         stmrs_pkg::PH_IDLE: ;
         default: begin
            s = enter_phase(s, stmrs_pkg::PH_IDLE, cfg);
         end
      endcase

      state_in = accept ? s : state_ff;
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= stmrs_pkg::PH_STARTUP;
         state_ff.chp   <= '0;
         state_ff.tc    <= '0;
         state_ff.pc    <= '0;
         state_ff.clk   <= 1'b0;
         state_ff.dir   <= 1'b0;
         state_ff.en    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads on each transfer; hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_step_clock_ff    <= out_clk;
         rsp_direction_ff     <= out_dir;
         rsp_driver_enable_ff <= out_en;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_clock    = rsp_step_clock_ff;
   assign rsp_direction     = rsp_direction_ff;
   assign rsp_driver_enable = rsp_driver_enable_ff;

   // A move in progress always has the driver enabled.
   a_move_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != stmrs_pkg::PH_STARTUP && state_ff.phase != stmrs_pkg::PH_IDLE)
      |-> state_ff.en)
      else $error("move phase with driver disabled");

   // The reversal pause holds the step clock low on the return direction.
   a_pause_levels: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == stmrs_pkg::PH_PAUSE) |-> (!state_ff.clk && state_ff.dir))
      else $error("pause with wrong step or direction level");

   // A transfer in always leaves a result waiting on the next cycle.
   a_result_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // The sequencer state advances only on a transfer in.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("state changed without a transfer");

endmodule
